### sv/sha256_stream_hasher_macros.svh
// Assertion macros for the hasher top level (sha256_stream_hasher.sv).
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, quiet while reset is held.
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/shs_pkg.sv
// Types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       step;
    } t_sched_ctl;

    typedef struct packed {
        logic load_work;
        logic round_en;
        logic fold;
        logic restart;
    } t_comp_ctl;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [7:0] PAD_ZERO      = 8'h00;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sml_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word sml_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

### sv/shs_in_if.sv
// Input channel: one message byte or a finish command per word.
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

### sv/shs_out_if.sv
// Output channel: one 32-bit digest word per handshake.
interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### sv/sha256_stream_hasher.sv
// SHA-256 over a byte stream. A data word is taken while the block is idle; the
// byte that completes a 64-byte block then holds the input off while the single shared
// round unit runs the 64 rounds, one per cycle, and then adds into the chaining words. A
// finish word feeds the padding bytes through the same byte path, one per cycle (64 minus the
// fill level, plus 64 more when the length does not fit), runs one or two compressions, and
// then presents the eight digest words, one per cycle as the sink takes them, most
// significant first. After the last digest word the hasher is back at its initial hash
// values and takes the next message.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    shs_in_if.sink      i_in,
    shs_out_if.source   o_out
);

`include "sha256_stream_hasher_macros.svh"

    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_fill;
    logic [5:0] r_round;
    logic [2:0] r_out_idx;
    logic [63:0] r_bit_count;
    logic       r_padding;
    logic       r_mark_done;
    logic       r_extra;
    logic       r_final;

    t_sched_ctl sched_ctl;
    t_comp_ctl  comp_ctl;
    t_word      w_cur;
    t_word      chain [8];

    logic       in_fire;
    logic       out_fire;
    logic       len_phase;
    logic [7:0] len_byte;
    logic [7:0] pad_byte;
    logic       block_done;
    logic       msg_done;

    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_cur)
    );

    shs_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (comp_ctl),
        .i_round (r_round),
        .i_w     (w_cur),
        .o_chain (chain)
    );

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign msg_done = out_fire && (r_out_idx == LAST_WORD_IDX);

    // Length bytes go in big-endian at positions 56 to 63 of the final block only.
    assign len_phase = r_mark_done && !r_extra && (r_fill[5:3] == 3'b111);
    assign len_byte  = 8'(r_bit_count >> {~r_fill[2:0], 3'b000});

    always_comb begin
        if (!r_mark_done) begin
            pad_byte = PAD_MARK;
        end else if (len_phase) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = PAD_ZERO;
        end
    end

    assign block_done = sched_ctl.load_byte && (r_fill == LAST_POS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind) begin
                        n_state = ST_PAD;
                    end else if (r_fill == LAST_POS) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LAST_POS) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (msg_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        sched_ctl          = '0;
        comp_ctl           = '0;
        i_in.ready         = 1'b0;
        o_out.valid        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready          = 1'b1;
                sched_ctl.load_byte = in_fire && !i_in.kind;
                sched_ctl.byte_val  = i_in.data_byte;
            end
            ST_PAD: begin
                sched_ctl.load_byte = 1'b1;
                sched_ctl.byte_val  = pad_byte;
            end
            ST_COMP: begin
                sched_ctl.step    = 1'b1;
                comp_ctl.round_en = 1'b1;
            end
            ST_FOLD: begin
                comp_ctl.fold = 1'b1;
            end
            ST_OUT: begin
                o_out.valid      = 1'b1;
                comp_ctl.restart = msg_done;
            end
            default: begin
                sched_ctl = '0;
            end
        endcase
        comp_ctl.load_work = block_done;
    end

    assign o_out.digest_word = chain[r_out_idx];
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = (r_out_idx == LAST_WORD_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_bit_count <= '0;
            r_padding   <= 1'b0;
            r_mark_done <= 1'b0;
            r_extra     <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sched_ctl.load_byte) begin
                r_fill <= r_fill + 6'd1;
            end
            r_round <= (r_state == ST_COMP) ? r_round + 6'd1 : '0;
            if (out_fire) begin
                r_out_idx <= r_out_idx + 3'd1;
            end
            if (in_fire && !i_in.kind) begin
                r_bit_count <= r_bit_count + BITS_PER_BYTE;
            end
            if (in_fire && i_in.kind) begin
                r_padding <= 1'b1;
            end
            if (r_state == ST_PAD && !r_mark_done) begin
                r_mark_done <= 1'b1;
                // No room for the length after the marker: one more block follows.
                r_extra     <= (r_fill[5:3] == 3'b111);
            end
            if (r_state == ST_FOLD) begin
                r_extra <= 1'b0;
            end
            if (r_state == ST_PAD && len_phase && r_fill == LAST_POS) begin
                r_final <= 1'b1;
            end
            if (msg_done) begin
                r_bit_count <= '0;
                r_padding   <= 1'b0;
                r_mark_done <= 1'b0;
                r_final     <= 1'b0;
            end
        end
    end

    `SHS_ASSERT(a_out_fill_zero, i_clk, i_rst_n, o_out.valid |-> (r_fill == '0), "fill level not zero while the digest is shown")
    `SHS_ASSERT(a_comp_starts_round0, i_clk, i_rst_n, $rose(r_state == ST_COMP) |-> (r_round == '0), "compression entered at a nonzero round")
    `SHS_ASSERT(a_msg_restart, i_clk, i_rst_n, msg_done |=> (r_state == ST_IDLE && r_bit_count == '0 && !r_padding), "message state not cleared after the last digest word")
    `SHS_ASSERT_ALWAYS(a_no_overlap, i_clk, !(i_in.ready && o_out.valid), "input taken while a digest word is pending")
    `SHS_ASSERT(a_final_only_padding, i_clk, i_rst_n, r_final |-> (r_padding && r_mark_done), "final block flagged outside padding")

endmodule

### sv/shs_sched.sv
// Block window: collects message bytes and expands the message schedule.
module shs_sched
    import shs_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    output t_word      o_w
);

    t_word r_window [16];
    t_word n_window [16];
    t_word w_next;

    assign w_next = sml_sig1(r_window[14]) + r_window[9] + sml_sig0(r_window[1]) + r_window[0];

    always_comb begin
        n_window = r_window;
        if (i_ctl.load_byte) begin
            // The window is one 512-bit shift line; a byte enters at the low end.
            for (int j = 0; j < 15; j++) begin
                n_window[j] = {r_window[j][23:0], r_window[j + 1][31:24]};
            end
            n_window[15] = {r_window[15][23:0], i_ctl.byte_val};
        end else if (i_ctl.step) begin
            for (int j = 0; j < 15; j++) begin
                n_window[j] = r_window[j + 1];
            end
            n_window[15] = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    assign o_w = r_window[0];

endmodule

### sv/shs_compress.sv
// Shared round unit with working variables and chaining words.
module shs_compress
    import shs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_comp_ctl i_ctl,
    input  logic [5:0] i_round,
    input  t_word     i_w,
    output t_word     o_chain [8]
);

    t_word r_chain [8];
    t_word r_work  [8];
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    always_comb begin
        ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
        t1  = r_work[7] + big_sig1(r_work[4]) + ch + ROUND_K[i_round] + i_w;
        t2  = big_sig0(r_work[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_work) begin
            r_work <= r_chain;
        end else if (i_ctl.round_en) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_chain <= INIT_HASH;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    assign o_chain = r_chain;

endmodule

### test/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher: random byte messages against a digest tracker.
module tb_sha256_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;
    import shs_pkg::*;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int unsigned ITEM_BUDGET  = 380;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN_CYCLES = 300;

    localparam logic [31:0] H0_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K256 [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    class digest_tracker;
        typedef struct packed {
            t_word      word;
            logic [2:0] index;
            logic       last;
        } t_digest_beat;

        t_word        chain [8];
        logic [63:0]  bit_total;
        logic [7:0]   blk [64];
        int unsigned  fill;
        t_digest_beat pending_digest_words [$];
        int unsigned  errors;
        int unsigned  words_checked;
        int unsigned  messages;
        int unsigned  bytes_hashed;

        function new();
            errors        = 0;
            words_checked = 0;
            messages      = 0;
            bytes_hashed  = 0;
            restart();
        endfunction

        function void restart();
            chain     = H0_WORDS;
            bit_total = '0;
            fill      = 0;
        endfunction

        function t_word rotr(t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void fold_block();
            t_word sched [64];
            t_word v [8];
            t_word s0, s1, t1, t2, ch, maj;
            int    i;
            for (i = 0; i < 16; i++) begin
                sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (i = 16; i < 64; i++) begin
                s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            v = chain;
            for (i = 0; i < 64; i++) begin
                s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
                s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t1  = v[7] + s1 + ch + K256[i] + sched[i];
                t2  = s0 + maj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (i = 0; i < 8; i++) begin
                chain[i] = chain[i] + v[i];
            end
        endfunction

        // Called for every accepted input word.
        function void take_word(logic kind, logic [7:0] data_byte);
            int           pos;
            int           i;
            t_digest_beat beat;
            if (kind == KIND_DATA) begin
                blk[fill] = data_byte;
                bit_total = bit_total + 64'd8;
                fill++;
                bytes_hashed++;
                if (fill == 64) begin
                    fold_block();
                    fill = 0;
                end
            end else begin
                // Padding: marker byte, zeros, then the big-endian bit length.
                pos = fill;
                blk[pos] = 8'h80;
                pos++;
                if (pos > 56) begin
                    while (pos < 64) begin
                        blk[pos] = 8'h00;
                        pos++;
                    end
                    fold_block();
                    pos = 0;
                end
                while (pos < 56) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                for (i = 0; i < 8; i++) begin
                    blk[56+i] = bit_total[63-8*i -: 8];
                end
                fold_block();
                for (i = 0; i < 8; i++) begin
                    beat.word  = chain[i];
                    beat.index = 3'(i);
                    beat.last  = (i == 7);
                    pending_digest_words.push_back(beat);
                end
                messages++;
                restart();
            end
        endfunction

        function void match_digest_word(t_word word, logic [2:0] index, logic last);
            t_digest_beat exp_beat;
            if (pending_digest_words.size() == 0) begin
                $error("unexpected digest word %h (index %0d)", word, index);
                errors++;
                return;
            end
            exp_beat = pending_digest_words.pop_front();
            words_checked++;
            if (word !== exp_beat.word) begin
                $error("digest_word mismatch: expected %h, actual %h", exp_beat.word, word);
                errors++;
            end
            if (index !== exp_beat.index) begin
                $error("word_index mismatch: expected %0d, actual %0d", exp_beat.index, index);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $error("last_word mismatch: expected %0b, actual %0b", exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    shs_in_if  in_if ();
    shs_out_if out_if ();

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    digest_tracker tracker = new();
    int unsigned   items_sent = 0;
    int unsigned   cycle_count = 0;
    int unsigned   sink_hold = 0;
    bit            calm = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short pauses, now and then a long one; none at all in a calm stretch.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin : sink_drive
        int unsigned hold;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_hold    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                tracker.match_digest_word(out_if.digest_word, out_if.word_index,
                                          out_if.last_word);
            end
            if (sink_hold != 0) begin
                out_if.ready <= 1'b0;
                sink_hold    <= sink_hold - 1;
            end else begin
                hold = gap_len();
                if (hold == 0) begin
                    out_if.ready <= 1'b1;
                end else begin
                    out_if.ready <= 1'b0;
                    sink_hold    <= hold - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Valid stays high across back-to-back words; it drops only for a pause or after the last word.
    task automatic send_word(input logic kind, input logic [7:0] data_byte);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.data_byte <= data_byte;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.take_word(kind, data_byte);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        int unsigned flavor;
        int unsigned j;
        logic [7:0]  b;
        flavor = $urandom_range(0, 9);
        calm   = ($urandom_range(0, 3) == 0);
        for (j = 0; j < len; j++) begin
            case (flavor)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(KIND_DATA, b);
        end
        // The byte that rides along with a finish must be ignored.
        send_word(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned msg_no;
        int unsigned len;
        int unsigned pick;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_DATA;
        in_if.data_byte = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty messages, one of them with a stray byte on the finish word, then two short messages.
        send_word(KIND_FINISH, 8'h00);
        send_word(KIND_FINISH, 8'hFF);
        send_word(KIND_DATA, 8'h61);
        send_word(KIND_DATA, 8'h62);
        send_word(KIND_DATA, 8'h63);
        send_word(KIND_FINISH, 8'h5A);
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_DATA, 8'h80);
        send_word(KIND_DATA, 8'h7F);
        send_word(KIND_FINISH, 8'hA5);

        // The first random messages sit on the padding boundaries: the length
        // just fits, just spills into an extra block, or fills whole blocks.
        msg_no = 0;
        while (items_sent < ITEM_BUDGET) begin
            pick = $urandom_range(0, 9);
            if (msg_no < 4) begin
                case (msg_no)
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 63;
                    default: len = 64;
                endcase
            end else if (pick < 4) begin
                len = $urandom_range(0, 10);
            end else if (pick < 6) begin
                len = (pick == 4) ? $urandom_range(52, 58) : $urandom_range(62, 66);
            end else if (pick == 6) begin
                len = $urandom_range(100, 140);
            end else begin
                len = $urandom_range(0, 70);
            end
            // The last message is cut short so the run ends near the item budget.
            if (len + 1 > ITEM_BUDGET - items_sent) begin
                len = ITEM_BUDGET - items_sent - 1;
            end
            send_message(len);
            msg_no++;
        end
        in_if.valid <= 1'b0;
        calm = 1'b0;

        while (tracker.pending_digest_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages (%0d bytes, %0d input words) and checked %0d digest words,",
                 tracker.messages, tracker.bytes_hashed, items_sent, tracker.words_checked);
        $display("including empty messages and lengths on both sides of the padding spill.");
        if (tracker.errors == 0 && tracker.pending_digest_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/shs_pkg.sv
sv/shs_in_if.sv
sv/shs_out_if.sv
sv/shs_sched.sv
sv/shs_compress.sv
sv/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
